>>> rtl/core/mscc_pkg.sv
`default_nettype none

package mscc_pkg;

    // Data store geometry: four byte banks, one byte lane each
    localparam int DATA_BYTES = 4096;
    localparam int DS_AW      = 12;
    localparam int NUM_BANKS  = 4;
    localparam int NUM_ROWS   = DATA_BYTES / NUM_BANKS;
    localparam int ROW_AW     = DS_AW - 2;

    localparam int NUM_REGS = 32;

    // Request operations
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WBYTE = 2'd1;
    localparam logic [1:0] OP_RBYTE = 2'd2;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    // Opcodes
    localparam logic [5:0] OPC_RTYPE = 6'd0;
    localparam logic [5:0] OPC_J     = 6'd2;
    localparam logic [5:0] OPC_BEQ   = 6'd4;
    localparam logic [5:0] OPC_ADDIU = 6'd9;
    localparam logic [5:0] OPC_LW    = 6'd35;
    localparam logic [5:0] OPC_SW    = 6'd43;

    // ALU codes, funct bits 2:0
    localparam logic [2:0] ALU_ADD = 3'd1;
    localparam logic [2:0] ALU_SUB = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_OR  = 3'd5;
    localparam logic [2:0] ALU_NOR = 3'd7;

    typedef struct packed {
        logic              wr_word;
        logic              rd_word;
        logic              wr_byte;
        logic              rd_byte;
        logic [DS_AW-1:0]  addr;
        logic [31:0]       word;
        logic [7:0]        bval;
    } t_ds_req;

    typedef struct packed {
        logic        halt;
        logic [31:0] pc;
        logic        wr_en;
        logic [4:0]  wr_idx;
        logic [31:0] val;
        logic        is_load;
        logic        mem_wr;
        logic [31:0] mem_addr;
        logic        rbyte;
    } t_exec_res;

endpackage

`default_nettype wire

>>> rtl/core/mscc_ram.sv
`default_nettype none

module mscc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/mscc_regfile.sv
`default_nettype none

module mscc_regfile (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [4:0]  i_rs,
    input  wire logic [4:0]  i_rt,
    input  wire logic        i_we,
    input  wire logic [4:0]  i_wa,
    input  wire logic [31:0] i_wd,
    output logic      [31:0] o_rs_val,
    output logic      [31:0] o_rt_val
);

    import mscc_pkg::*;

    logic [NUM_REGS-1:0] r_valid;
    logic [4:0]          r_rs;
    logic [4:0]          r_rt;
    logic                r_rs_vld;
    logic                r_rt_vld;
    logic                r_byp_en;
    logic [4:0]          r_byp_a;
    logic [31:0]         r_byp_d;
    logic [31:0]         rs_ram;
    logic [31:0]         rt_ram;
    logic                we;

    assign we = i_en && i_we;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[i_wa] <= 1'b1;
        end
    end

    // bypass holds the write that lands on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_en <= 1'b0;
        end else if (i_en) begin
            r_byp_en <= i_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rs     <= i_rs;
            r_rt     <= i_rt;
            r_rs_vld <= r_valid[i_rs];
            r_rt_vld <= r_valid[i_rt];
            r_byp_a  <= i_wa;
            r_byp_d  <= i_wd;
        end
    end

    mscc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rs_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_wa),
        .i_wdata (i_wd),
        .i_re    (i_en),
        .i_raddr (i_rs),
        .o_rdata (rs_ram)
    );

    mscc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rt_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_wa),
        .i_wdata (i_wd),
        .i_re    (i_en),
        .i_raddr (i_rt),
        .o_rdata (rt_ram)
    );

    // newest first: pending writeback, then same-edge write, then array
    always_comb begin
        if (i_we && i_wa == r_rs) begin
            o_rs_val = i_wd;
        end else if (r_byp_en && r_byp_a == r_rs) begin
            o_rs_val = r_byp_d;
        end else if (r_rs_vld) begin
            o_rs_val = rs_ram;
        end else begin
            o_rs_val = '0;
        end

        if (i_we && i_wa == r_rt) begin
            o_rt_val = i_wd;
        end else if (r_byp_en && r_byp_a == r_rt) begin
            o_rt_val = r_byp_d;
        end else if (r_rt_vld) begin
            o_rt_val = rt_ram;
        end else begin
            o_rt_val = '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mscc_dstore.sv
`default_nettype none

module mscc_dstore (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire mscc_pkg::t_ds_req i_req,
    output logic                   o_busy,
    output logic [31:0]            o_word,
    output logic [7:0]             o_byte
);

    import mscc_pkg::*;

    logic              r_clearing;
    logic [ROW_AW-1:0] r_clr_row;
    logic [1:0]        r_lo;
    logic [7:0]        rd [NUM_BANKS];

    // clearing pass after reset, one row of all banks per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ROW_AW'(NUM_ROWS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_busy = r_clearing;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= i_req.addr[1:0];
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        logic [1:0]       k;
        logic [DS_AW-1:0] ab;
        logic [7:0]       wd;
        logic             we_item;

        // k is this bank's byte position within the big-endian word
        assign k       = 2'(g) - i_req.addr[1:0];
        assign ab      = i_req.addr + DS_AW'(k);
        assign wd      = i_req.wr_byte ? i_req.bval : 8'(i_req.word >> {~k, 3'b000});
        assign we_item = i_en && (i_req.wr_word ||
                                  (i_req.wr_byte && i_req.addr[1:0] == 2'(g)));

        mscc_ram #(.WIDTH(8), .DEPTH(NUM_ROWS)) u_bank (
            .i_clk   (i_clk),
            .i_we    (r_clearing || we_item),
            .i_waddr (r_clearing ? r_clr_row : ab[DS_AW-1:2]),
            .i_wdata (r_clearing ? 8'd0 : wd),
            .i_re    (i_en),
            .i_raddr (ab[DS_AW-1:2]),
            .o_rdata (rd[g])
        );
    end

    always_comb begin
        logic [1:0] idx;
        idx    = '0;
        o_word = '0;
        for (int k = 0; k < NUM_BANKS; k++) begin
            idx = r_lo + 2'(k);
            o_word[8*(3-k) +: 8] = rd[idx];
        end
        o_byte = rd[r_lo];
    end

endmodule

`default_nettype wire

>>> rtl/core/mscc_execute.sv
`default_nettype none

module mscc_execute (
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_op,
    input  wire logic [31:0]   i_inst,
    input  wire logic [11:0]   i_baddr,
    input  wire logic [7:0]    i_bval,
    input  wire logic [31:0]   i_a,
    input  wire logic [31:0]   i_b,
    input  wire logic [31:0]   i_pc,
    input  wire logic          i_halt,
    output mscc_pkg::t_exec_res o_res,
    output mscc_pkg::t_ds_req   o_req
);

    import mscc_pkg::*;

    always_comb begin
        logic [5:0]  opcode;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [31:0] sext;
        logic [31:0] sum;
        logic [31:0] pc4;
        logic [31:0] npc;
        logic [31:0] alu;
        logic        wr;
        logic [4:0]  dest;
        logic [31:0] value;

        opcode = i_inst[31:26];
        rt     = i_inst[20:16];
        rd     = i_inst[15:11];
        sext   = {{16{i_inst[15]}}, i_inst[15:0]};
        sum    = i_a + sext;
        pc4    = i_pc + 32'd4;
        npc    = pc4;
        wr     = 1'b0;
        dest   = '0;
        value  = '0;

        case (i_inst[2:0])
            ALU_ADD: alu = i_a + i_b;
            ALU_SUB: alu = i_a - i_b;
            ALU_AND: alu = i_a & i_b;
            ALU_OR:  alu = i_a | i_b;
            ALU_NOR: alu = ~(i_a | i_b);
            default: alu = '0;
        endcase

        o_res      = '0;
        o_res.halt = i_halt;
        o_res.pc   = i_pc;

        o_req      = '0;
        o_req.addr = sum[DS_AW-1:0];
        o_req.word = i_b;
        o_req.bval = i_bval;

        if (i_valid) begin
            unique case (i_op)
                OP_EXEC: begin
                    if (!i_halt && i_inst == HALT_WORD) begin
                        o_res.halt = 1'b1;
                    end else if (!i_halt) begin
                        unique case (opcode)
                            OPC_RTYPE: begin
                                wr    = 1'b1;
                                dest  = rd;
                                value = alu;
                            end
                            OPC_ADDIU: begin
                                wr    = 1'b1;
                                dest  = rt;
                                value = sum;
                            end
                            OPC_LW: begin
                                wr             = 1'b1;
                                dest           = rt;
                                o_res.is_load  = 1'b1;
                                o_res.mem_addr = sum;
                                o_req.rd_word  = 1'b1;
                            end
                            OPC_SW: begin
                                o_res.mem_wr   = 1'b1;
                                o_res.mem_addr = sum;
                                o_req.wr_word  = 1'b1;
                            end
                            OPC_BEQ: begin
                                if (i_a == i_b) begin
                                    npc = pc4 + {sext[29:0], 2'b00};
                                end
                            end
                            OPC_J: begin
                                npc = {pc4[31:28], i_inst[25:0], 2'b00};
                            end
                            default: ;
                        endcase
                        // register zero is never written
                        if (wr && dest != 5'd0) begin
                            o_res.wr_en  = 1'b1;
                            o_res.wr_idx = dest;
                            o_res.val    = value;
                        end
                        o_res.pc = npc;
                    end
                end
                OP_WBYTE: begin
                    o_req.addr    = i_baddr;
                    o_req.wr_byte = 1'b1;
                end
                OP_RBYTE: begin
                    o_req.addr    = i_baddr;
                    o_req.rd_byte = 1'b1;
                    o_res.rbyte   = 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mips_single_cycle_core_top.sv
`default_nettype none

// Single-cycle MIPS subset core (addu/subu/and/or/nor, addiu, lw, sw, beq, j;
// all-ones word halts for good). One request per clock while o_stall is
// low: a taken request is registered in the issue stage and executed there,
// the data store answers into the memory / writeback stage, and the result
// register drives the output. Back-to-back dependent instructions, including
// a load followed by its use, run at full rate through forwarding. The 4 KiB
// data store is four byte-wide banks read and written in one pass, so
// unaligned and wrapping word accesses cost nothing extra. After reset the
// store is zeroed by a clearing pass during which o_stall stays high. A
// stalled output freezes the whole pipeline.
module mips_single_cycle_core_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_instruction,
    input  wire logic [11:0] i_byte_address,
    input  wire logic [7:0]  i_byte_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_halted,
    output logic [31:0]      o_next_pc,
    output logic             o_reg_written,
    output logic [4:0]       o_reg_index,
    output logic [31:0]      o_reg_value,
    output logic             o_mem_written,
    output logic [31:0]      o_mem_address,
    output logic [7:0]       o_read_byte
);

    import mscc_pkg::*;

    logic        adv;
    logic        ds_busy;
    logic        accept;

    logic [31:0] r_pc;
    logic        r_halt;

    logic        r_a_valid;
    logic [1:0]  r_a_op;
    logic [31:0] r_a_inst;
    logic [11:0] r_a_baddr;
    logic [7:0]  r_a_bval;

    logic        r_b_valid;
    t_exec_res   r_b;

    logic        r_o_valid;
    t_exec_res   r_o;
    logic [31:0] r_o_val;
    logic [7:0]  r_o_byte;

    logic [31:0] rs_val;
    logic [31:0] rt_val;
    t_exec_res   exec_res;
    t_ds_req     ds_req;
    logic [31:0] ds_word;
    logic [7:0]  ds_byte;
    logic [31:0] wb_val;
    logic        wb_we;

    assign adv     = !r_o_valid || !i_stall;
    assign o_stall = ds_busy || !adv;
    assign accept  = i_valid && !o_stall;

    // issue stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_op    <= i_operation;
            r_a_inst  <= i_instruction;
            r_a_baddr <= i_byte_address;
            r_a_bval  <= i_byte_value;
        end
    end

    mscc_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_rs     (i_instruction[25:21]),
        .i_rt     (i_instruction[20:16]),
        .i_we     (wb_we),
        .i_wa     (r_b.wr_idx),
        .i_wd     (wb_val),
        .o_rs_val (rs_val),
        .o_rt_val (rt_val)
    );

    mscc_execute u_execute (
        .i_valid (r_a_valid),
        .i_op    (r_a_op),
        .i_inst  (r_a_inst),
        .i_baddr (r_a_baddr),
        .i_bval  (r_a_bval),
        .i_a     (rs_val),
        .i_b     (rt_val),
        .i_pc    (r_pc),
        .i_halt  (r_halt),
        .o_res   (exec_res),
        .o_req   (ds_req)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_halt <= 1'b0;
        end else if (adv && r_a_valid) begin
            r_pc   <= exec_res.pc;
            r_halt <= exec_res.halt;
        end
    end

    mscc_dstore u_dstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_req   (ds_req),
        .o_busy  (ds_busy),
        .o_word  (ds_word),
        .o_byte  (ds_byte)
    );

    // memory / writeback stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b <= exec_res;
        end
    end

    assign wb_val = r_b.is_load ? ds_word : r_b.val;
    assign wb_we  = r_b_valid && r_b.wr_en;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o      <= r_b;
            r_o_val  <= r_b.wr_en ? wb_val : 32'd0;
            r_o_byte <= r_b.rbyte ? ds_byte : 8'd0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_halted      = r_o.halt;
    assign o_next_pc     = r_o.pc;
    assign o_reg_written = r_o.wr_en;
    assign o_reg_index   = r_o.wr_idx;
    assign o_reg_value   = r_o_val;
    assign o_mem_written = r_o.mem_wr;
    assign o_mem_address = r_o.mem_addr;
    assign o_read_byte   = r_o_byte;

endmodule

`default_nettype wire
